/* src/pvbf_pkg.sv */
`timescale 1ns / 1ps
package pvbf_pkg;

  // item field widths
  localparam int BIN_W     = 9;
  localparam int PHASE_W   = 16;
  localparam int FREQ_W    = 24;
  localparam int BIN_COUNT = 1 << BIN_W;

  // register widths
  localparam int SPACING_W = 20;
  localparam int TURN_W    = 24;
  localparam int INV_W     = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 32;

  // stream beat widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // arithmetic widths
  localparam int EXP_W    = BIN_W + 1 + SPACING_W;   // (bin+1)*spacing
  localparam int ERR_W    = EXP_W + 1;               // frequency minus expected
  localparam int PROD_W   = PHASE_W + TURN_W + 1;    // signed diff times turn rate
  localparam int FRAC_W   = 16;                      // Q32 to Q16, Q16 to whole
  localparam int SCALED_W = PROD_W - FRAC_W;
  localparam int FSUM_W   = 32;

  localparam logic [INV_W-1:0] ROUND_HALF = INV_W'(1) << (FRAC_W - 1);
  localparam logic signed [FSUM_W-1:0] FREQ_MAX = FSUM_W'((1 << (FREQ_W - 1)) - 1);
  localparam logic signed [FSUM_W-1:0] FREQ_MIN = -(FSUM_W'(1) << (FREQ_W - 1));

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SPACING = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INV_TURN    = CFG_IDX_W'(3);

  typedef enum logic {
    MODE_ANALYSE    = 1'b0,
    MODE_SYNTHESISE = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic [SPACING_W-1:0] bin_spacing;
    logic [TURN_W-1:0]    turn_rate;
    logic [INV_W-1:0]     inverse_turn_rate;
  } cfg_t;

  // one classified bin on its way from the front to the back
  typedef struct packed {
    logic [BIN_W-1:0]   bin;
    logic               restart;
    mode_t              mode;
    logic [PHASE_W-1:0] phase;     // analyse: new phase
    logic [PHASE_W-1:0] inc;       // synthesise: phase increment
    logic [EXP_W-1:0]   expected;  // expected bin advance
  } work_t;

endpackage

/* src/phase_vocoder_bin_frequency.sv */
`timescale 1ns / 1ps
// Phase vocoder bin stage. Each beat on the input stream is one spectral bin.
// In analyse mode the bin's stored phase is taken from the new phase, the
// difference wrapped in Q16 turns, scaled by turn_rate and added to the
// expected advance (bin+1)*bin_spacing to give a saturated frequency; the new
// phase is stored. In synthesise mode the expected advance is taken from the
// input frequency, scaled by inverse_turn_rate to a Q16 phase step and
// accumulated into the stored phase, which is output. restart zeroes the
// bin's phase before use. One bin is taken every cycle while the output is
// not stalled, also when the same bin follows itself: the phase store is read
// and written once per bin in a single back stage with a bypass of the last
// write. From input to output beat the path runs through two front stages
// (expected advance, then the Q32 phase step multiply), the queue, and four
// back stages (store read, phase resolve and write, turn rate multiply,
// rounding and saturation). After reset the 512-entry phase store is cleared,
// during which s_tready stays low; configuration writes are taken at any time
// but must only be issued while the block is idle.
module phase_vocoder_bin_frequency import pvbf_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // bin_index, phase_in, frequency_in
  input  logic                  s_tuser,   // restart
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // bin_out, frequency_out, phase_out
  output logic                  m_tuser,   // saturated
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_t                      cfg;
  logic                      clearing;
  logic                      front_ready;
  logic                      push;
  logic                      push_ready;
  work_t                     push_entry;
  logic                      pop;
  logic                      avail;
  work_t                     pop_entry;
  logic [BIN_W-1:0]          out_bin;
  logic signed [FREQ_W-1:0]  out_freq;
  logic signed [PHASE_W-1:0] out_phase;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode              <= MODE_ANALYSE;
      cfg.bin_spacing       <= SPACING_W'(750);
      cfg.turn_rate         <= TURN_W'(3000);
      cfg.inverse_turn_rate <= INV_W'(1431655);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:        cfg.mode              <= mode_t'(cfg_data[0]);
        REG_BIN_SPACING: cfg.bin_spacing       <= cfg_data[SPACING_W-1:0];
        REG_TURN_RATE:   cfg.turn_rate         <= cfg_data[TURN_W-1:0];
        REG_INV_TURN:    cfg.inverse_turn_rate <= cfg_data[INV_W-1:0];
        default:         ;
      endcase
    end
  end

  // hold the input while the phase store is swept
  assign s_tready = front_ready && !clearing;

  pvbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid && !clearing),
    .in_ready   (front_ready),
    .in_bin     (s_tdata[BIN_W-1:0]),
    .in_restart (s_tuser),
    .in_phase   (s_tdata[BIN_W+PHASE_W-1:BIN_W]),
    .in_freq    (s_tdata[BIN_W+PHASE_W+FREQ_W-1:BIN_W+PHASE_W]),
    .push       (push),
    .push_ready (push_ready),
    .entry      (push_entry)
  );

  pvbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .wdata      (push_entry),
    .pop        (pop),
    .avail      (avail),
    .rdata      (pop_entry)
  );

  pvbf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .avail     (avail),
    .pop       (pop),
    .entry     (pop_entry),
    .clearing  (clearing),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_bin   (out_bin),
    .out_freq  (out_freq),
    .out_phase (out_phase),
    .out_sat   (m_tuser)
  );

  assign m_tdata = {{(OUT_DATA_W - BIN_W - FREQ_W - PHASE_W){1'b0}},
                    out_phase, out_freq, out_bin};

endmodule

/* src/pvbf_front.sv */
`timescale 1ns / 1ps
module pvbf_front import pvbf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [BIN_W-1:0]          in_bin,
  input  logic                      in_restart,
  input  logic signed [PHASE_W-1:0] in_phase,
  input  logic signed [FREQ_W-1:0]  in_freq,
  output logic                      push,
  input  logic                      push_ready,
  output work_t                     entry
);

  logic                      f1_valid;
  logic [BIN_W-1:0]          f1_bin;
  logic                      f1_restart;
  mode_t                     f1_mode;
  logic [PHASE_W-1:0]        f1_phase;
  logic signed [FREQ_W-1:0]  f1_freq;
  logic [EXP_W-1:0]          f1_expected;

  logic                      f2_valid;
  logic [BIN_W-1:0]          f2_bin;
  logic                      f2_restart;
  mode_t                     f2_mode;
  logic [PHASE_W-1:0]        f2_phase;
  logic [EXP_W-1:0]          f2_expected;
  logic signed [ERR_W-1:0]   f2_err;

  logic                      f1_adv;
  logic                      f2_adv;
  logic [BIN_W:0]            bin_plus;
  logic [EXP_W-1:0]          expected_c;
  logic signed [ERR_W-1:0]   err_c;
  logic [INV_W-1:0]          err_ext;
  logic [INV_W-1:0]          prod_lo;
  logic [INV_W-1:0]          inc_sum;

  assign f2_adv   = !f2_valid || push_ready;
  assign f1_adv   = !f1_valid || f2_adv;
  assign in_ready = f1_adv;
  assign push     = f2_valid;

  always_comb begin
    bin_plus   = {1'b0, in_bin} + (BIN_W + 1)'(1);
    expected_c = EXP_W'(bin_plus * cfg.bin_spacing);
    err_c      = $signed({{(ERR_W - FREQ_W){f1_freq[FREQ_W-1]}}, f1_freq})
               - $signed({1'b0, f1_expected});
    // only the low word of the product reaches the Q16 increment
    err_ext    = {{(INV_W - ERR_W){f2_err[ERR_W-1]}}, f2_err};
    prod_lo    = INV_W'(err_ext * cfg.inverse_turn_rate);
    inc_sum    = prod_lo + ROUND_HALF;
  end

  always_comb begin
    entry.bin      = f2_bin;
    entry.restart  = f2_restart;
    entry.mode     = f2_mode;
    entry.phase    = f2_phase;
    entry.inc      = inc_sum[INV_W-1:INV_W-PHASE_W];
    entry.expected = f2_expected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (f1_adv) f1_valid <= in_valid;
      if (f2_adv) f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_adv && in_valid) begin
      f1_bin      <= in_bin;
      f1_restart  <= in_restart;
      f1_mode     <= cfg.mode;
      f1_phase    <= in_phase;
      f1_freq     <= in_freq;
      f1_expected <= expected_c;
    end
    if (f2_adv && f1_valid) begin
      f2_bin      <= f1_bin;
      f2_restart  <= f1_restart;
      f2_mode     <= f1_mode;
      f2_phase    <= f1_phase;
      f2_expected <= f1_expected;
      f2_err      <= err_c;
    end
  end

endmodule

/* src/pvbf_queue.sv */
`timescale 1ns / 1ps
module pvbf_queue import pvbf_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  push_ready,
  input  work_t wdata,
  input  logic  pop,
  output logic  avail,
  output work_t rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;

  assign push_ready = count != CNT_W'(DEPTH);
  assign avail      = count != '0;
  assign rdata      = store[rd_ptr];
  assign wr_en      = push && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)   rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({wr_en, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_ptr] <= wdata;
  end

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

/* src/pvbf_back.sv */
`timescale 1ns / 1ps
module pvbf_back import pvbf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      avail,
  output logic                      pop,
  input  work_t                     entry,
  output logic                      clearing,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [BIN_W-1:0]          out_bin,
  output logic signed [FREQ_W-1:0]  out_freq,
  output logic signed [PHASE_W-1:0] out_phase,
  output logic                      out_sat
);

  logic [PHASE_W-1:0]        mem [BIN_COUNT];
  logic [PHASE_W-1:0]        rd_data;
  logic [BIN_W-1:0]          clr_addr;

  logic                      lw_valid;
  logic [BIN_W-1:0]          lw_addr;
  logic [PHASE_W-1:0]        lw_data;

  logic                      b1_valid;
  work_t                     b1;

  logic                      b2_valid;
  logic [BIN_W-1:0]          b2_bin;
  mode_t                     b2_mode;
  logic [PHASE_W-1:0]        b2_phase;
  logic signed [PHASE_W-1:0] b2_diff;
  logic [EXP_W-1:0]          b2_expected;

  logic                      b3_valid;
  logic [BIN_W-1:0]          b3_bin;
  mode_t                     b3_mode;
  logic [PHASE_W-1:0]        b3_phase;
  logic signed [PROD_W-1:0]  b3_prod;
  logic [EXP_W-1:0]          b3_expected;

  logic                      out_adv;
  logic                      b3_adv;
  logic                      b2_adv;
  logic                      b1_adv;
  logic                      b1_fire;
  logic [PHASE_W-1:0]        prev;
  logic [PHASE_W-1:0]        new_phase;
  logic [PHASE_W-1:0]        diff_c;
  logic                      wr_en;
  logic [BIN_W-1:0]          wr_addr;
  logic [PHASE_W-1:0]        wr_data;
  logic [PROD_W-1:0]         round_sum;
  logic signed [FSUM_W-1:0]  f_sum;
  logic [FREQ_W-1:0]         freq_c;
  logic                      sat_c;
  logic [PHASE_W-1:0]        phase_c;

  assign out_adv = !out_valid || out_ready;
  assign b3_adv  = !b3_valid || out_adv;
  assign b2_adv  = !b2_valid || b3_adv;
  assign b1_adv  = !b1_valid || b2_adv;
  assign b1_fire = b1_valid && b2_adv;
  assign pop     = avail && b1_adv && !clearing;

  // resolve the stored phase: restart first, then the last write, then the store read
  always_comb begin
    if (b1.restart) begin
      prev = '0;
    end else if (lw_valid && lw_addr == b1.bin) begin
      prev = lw_data;
    end else begin
      prev = rd_data;
    end
    diff_c    = b1.phase - prev;
    new_phase = (b1.mode == MODE_SYNTHESISE) ? prev + b1.inc : b1.phase;
    wr_en     = clearing || b1_fire;
    wr_addr   = clearing ? clr_addr : b1.bin;
    wr_data   = clearing ? '0 : new_phase;
  end

  always_ff @(posedge clk) begin
    if (pop) rd_data <= mem[entry.bin];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      lw_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + BIN_W'(1);
        if (clr_addr == BIN_W'(BIN_COUNT - 1)) clearing <= 1'b0;
      end
      if (clearing) begin
        lw_valid <= 1'b0;
      end else if (b1_fire) begin
        lw_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_fire) begin
      lw_addr <= b1.bin;
      lw_data <= new_phase;
    end
  end

  // round half up, drop the fraction, add the expected advance, clip; synthesise passes the phase
  always_comb begin
    round_sum = PROD_W'(b3_prod) + PROD_W'(ROUND_HALF);
    f_sum     = $signed({{(FSUM_W - SCALED_W){round_sum[PROD_W-1]}},
                         round_sum[PROD_W-1:FRAC_W]})
              + $signed({{(FSUM_W - EXP_W){1'b0}}, b3_expected});
    if (b3_mode == MODE_SYNTHESISE) begin
      freq_c  = '0;
      sat_c   = 1'b0;
      phase_c = b3_phase;
    end else if (f_sum > FREQ_MAX) begin
      freq_c  = FREQ_MAX[FREQ_W-1:0];
      sat_c   = 1'b1;
      phase_c = '0;
    end else if (f_sum < FREQ_MIN) begin
      freq_c  = FREQ_MIN[FREQ_W-1:0];
      sat_c   = 1'b1;
      phase_c = '0;
    end else begin
      freq_c  = f_sum[FREQ_W-1:0];
      sat_c   = 1'b0;
      phase_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b1_adv)  b1_valid  <= pop;
      if (b2_adv)  b2_valid  <= b1_valid;
      if (b3_adv)  b3_valid  <= b2_valid;
      if (out_adv) out_valid <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) b1 <= entry;
    if (b1_fire) begin
      b2_bin      <= b1.bin;
      b2_mode     <= b1.mode;
      b2_phase    <= new_phase;
      b2_diff     <= diff_c;
      b2_expected <= b1.expected;
    end
    if (b3_adv && b2_valid) begin
      b3_bin      <= b2_bin;
      b3_mode     <= b2_mode;
      b3_phase    <= b2_phase;
      b3_prod     <= b2_diff * $signed({1'b0, cfg.turn_rate});
      b3_expected <= b2_expected;
    end
    if (out_adv && b3_valid) begin
      out_bin   <= b3_bin;
      out_freq  <= freq_c;
      out_phase <= phase_c;
      out_sat   <= sat_c;
    end
  end

  a_sat_at_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sat |->
      (out_freq == FREQ_MAX[FREQ_W-1:0]) || (out_freq == FREQ_MIN[FREQ_W-1:0]))
    else $error("saturated result not at a rail");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_freq != '0 || out_sat) |-> out_phase == '0)
    else $error("analyse result carries a phase");

  a_full_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == BIN_W'(BIN_COUNT - 1))
    else $error("phase store sweep ended early");

endmodule
